// ----- sv/htd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

	// item kinds carried on the input tuser
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_SET_UP   = 3'd1,
		OP_SET_DOWN = 3'd2,
		OP_PWR_UP   = 3'd3,
		OP_PWR_DOWN = 3'd4,
		OP_PAUSE    = 3'd5,
		OP_SAMPLE   = 3'd6
	} op_t;

	// reported status codes
	typedef enum logic [1:0] {
		ST_START   = 2'd0,
		ST_WORKING = 2'd1,
		ST_WARM    = 2'd2,
		ST_PAUSED  = 2'd3
	} status_t;

	localparam logic [6:0] TEMP_MIN     = 7'd30;
	localparam logic [6:0] TEMP_MAX     = 7'd70;
	localparam logic [6:0] TEMP_RESET   = 7'd42;
	localparam logic [6:0] POWER_STEP   = 7'd10;
	localparam logic [6:0] POWER_MAX    = 7'd100;
	localparam logic [6:0] POWER_RESET  = 7'd50;
	localparam logic [3:0] TENTHS_FULL  = 4'd10;
	localparam logic [3:0] TENTHS_RESET = 4'd5;
	localparam logic [8:0] PHASE_FULL   = 9'd256;
	localparam logic [8:0] PHASE_RESET  = 9'd21;

	// on/off split of one drive period, in tenths
	typedef struct packed {
		logic [3:0] on_tenths;
		logic [3:0] off_tenths;
		logic       always_on;
		logic       blanked;
	} ratio_t;

	// power in percent to on/off tenths; p/10 as (p*205)>>11, exact below 1029
	function automatic ratio_t load_ratio(input logic [6:0] power);
		logic [14:0] prod;
		ratio_t      r;
		prod = 15'(power) * 15'd205;
		r.on_tenths  = prod[14:11];
		r.off_tenths = TENTHS_FULL - prod[14:11];
		r.always_on  = 1'b0;
		r.blanked    = 1'b0;
		if (power == 7'd0) begin
			r.on_tenths  = 4'd0;
			r.off_tenths = 4'd0;
			r.blanked    = 1'b1;
		end else if (power >= POWER_MAX) begin
			r.on_tenths  = TENTHS_FULL;
			r.off_tenths = 4'd0;
			r.always_on  = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/heater_thermostat_triac_drive_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Heater thermostat with time-proportional triac drive. Each input transfer is
// a tick, a button event or a temperature sample (kind on s_axis_tuser) and
// yields exactly one result transfer with the drive level and the settings
// after that item. One item per clock: the whole update is done between the
// state registers and the result register in the accepting cycle, and a new
// transfer is taken whenever the result register is empty or being drained.
// Ticks count a phase counter; the on phase lasts on_tenths*TICKS_PER_TENTH+1
// ticks and the off phase off_tenths*TICKS_PER_TENTH+1 ticks while the load
// is cold, and held phases last 256 ticks.
module heater_thermostat_triac_drive_top #(
	parameter int TICKS_PER_TENTH = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // raw_sample[15:0]
	input  wire logic [2:0]  s_axis_tuser,  // op[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// drive_on[0], setpoint[7:1], power_percent[14:8], measured[26:15],
	// heating[27], status[29:28], zero[31:30]
	output logic [31:0]      m_axis_tdata
);
	import htd_pkg::*;

	// thermostat and drive state
	logic [6:0]  target_q, target_d;
	logic [6:0]  power_q, power_d;
	logic [11:0] temp_q, temp_d;
	ratio_t      ratio_q, ratio_d;
	logic        warm_q, warm_d;
	logic        next_on_q, next_on_d;
	logic        working_q, working_d;
	logic        saved_q, saved_d;
	logic        paused_q, paused_d;
	logic [8:0]  phase_q, phase_d;
	logic        drive_q, drive_d;
	status_t     status_q, status_d;

	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic        in_xfer;
	op_t         op;
	logic [11:0] sample_whole;
	logic [8:0]  on_reload;
	logic [8:0]  off_reload;
	logic        run_rule;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign op            = op_t'(s_axis_tuser);

	// sample / 16 truncated toward zero
	assign sample_whole = s_axis_tdata[15:4]
		+ 12'(s_axis_tdata[15] && (s_axis_tdata[3:0] != 4'd0));

	assign on_reload  = 9'(int'(ratio_q.on_tenths) * TICKS_PER_TENTH + 1);
	assign off_reload = 9'(int'(ratio_q.off_tenths) * TICKS_PER_TENTH + 1);

	// next state for one item
	always_comb begin
		target_d  = target_q;
		power_d   = power_q;
		temp_d    = temp_q;
		ratio_d   = ratio_q;
		warm_d    = warm_q;
		next_on_d = next_on_q;
		working_d = working_q;
		saved_d   = saved_q;
		paused_d  = paused_q;
		phase_d   = phase_q;
		drive_d   = drive_q;
		status_d  = status_q;
		run_rule  = 1'b0;

		unique case (op)
			OP_TICK: begin
				if (phase_q > 9'd1) begin
					phase_d = phase_q - 9'd1;
				end else if (ratio_q.always_on) begin
					next_on_d = 1'b1;
					drive_d   = 1'b1;
					phase_d   = PHASE_FULL;
				end else if (ratio_q.blanked) begin
					next_on_d = 1'b0;
					drive_d   = 1'b0;
					phase_d   = PHASE_FULL;
				end else if (!warm_q) begin
					drive_d   = next_on_q;
					next_on_d = !next_on_q;
					phase_d   = next_on_q ? on_reload : off_reload;
				end else begin
					phase_d = PHASE_FULL;
				end
			end
			OP_PAUSE: begin
				if (!paused_q) begin
					saved_d         = working_q;
					working_d       = 1'b0;
					ratio_d.blanked = 1'b1;
					status_d        = ST_PAUSED;
					paused_d        = 1'b1;
				end else begin
					working_d = saved_q;
					ratio_d   = load_ratio(power_q);
					paused_d  = 1'b0;
					run_rule  = 1'b1;
				end
			end
			OP_SAMPLE: begin
				temp_d   = sample_whole;
				run_rule = !paused_q;
			end
			OP_SET_UP: begin
				if (!paused_q) begin
					if (target_q < TEMP_MAX) target_d = target_q + 7'd1;
					run_rule = 1'b1;
				end
			end
			OP_SET_DOWN: begin
				if (!paused_q) begin
					if (target_q > TEMP_MIN) target_d = target_q - 7'd1;
					run_rule = 1'b1;
				end
			end
			OP_PWR_UP: begin
				if (!paused_q) begin
					if (power_q < POWER_MAX) power_d = power_q + POWER_STEP;
					ratio_d  = load_ratio(power_d);
					run_rule = 1'b1;
				end
			end
			OP_PWR_DOWN: begin
				if (!paused_q) begin
					if (power_q > 7'd0) power_d = power_q - POWER_STEP;
					ratio_d  = load_ratio(power_d);
					run_rule = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// on/off thermostat rule
		if (run_rule) begin
			if ($signed(temp_d) < $signed({5'd0, target_d})) begin
				warm_d = 1'b0;
				if (!working_d) begin
					status_d  = ST_WORKING;
					ratio_d   = load_ratio(power_d);
					working_d = 1'b1;
				end
			end else begin
				warm_d = 1'b1;
				if (working_d) begin
					status_d        = ST_WARM;
					ratio_d.blanked = 1'b1;
					working_d       = 1'b0;
				end
			end
		end
	end

	// state registers, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= TEMP_RESET;
			power_q   <= POWER_RESET;
			temp_q    <= 12'd0;
			ratio_q   <= '{on_tenths: TENTHS_RESET, off_tenths: TENTHS_RESET,
				always_on: 1'b0, blanked: 1'b0};
			warm_q    <= 1'b0;
			next_on_q <= 1'b0;
			working_q <= 1'b0;
			saved_q   <= 1'b0;
			paused_q  <= 1'b0;
			phase_q   <= PHASE_RESET;
			drive_q   <= 1'b1;
			status_q  <= ST_START;
		end else if (in_xfer) begin
			target_q  <= target_d;
			power_q   <= power_d;
			temp_q    <= temp_d;
			ratio_q   <= ratio_d;
			warm_q    <= warm_d;
			next_on_q <= next_on_d;
			working_q <= working_d;
			saved_q   <= saved_d;
			paused_q  <= paused_d;
			phase_q   <= phase_d;
			drive_q   <= drive_d;
			status_q  <= status_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= {2'b00, status_d, working_d, temp_d, power_d, target_d, drive_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// while paused no cycle runs and the status reads paused
	a_paused_idle: assert property (@(posedge clk) disable iff (!arst_n)
		paused_q |-> (!working_q && status_q == ST_PAUSED))
		else $error("paused with a heating cycle active");

	// phase counter never sits at zero and never exceeds a full phase
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != 9'd0) && (phase_q <= PHASE_FULL))
		else $error("phase counter out of range");

	// setpoint and power stay clamped
	a_settings_range: assert property (@(posedge clk) disable iff (!arst_n)
		(target_q >= TEMP_MIN) && (target_q <= TEMP_MAX) && (power_q <= POWER_MAX))
		else $error("setting out of range");

	// a result that is not taken leaves the state untouched
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> ($stable(phase_q) && $stable(drive_q)))
		else $error("state changed while result stalled");

endmodule

`default_nettype wire

// ----- verif/tb_heater_thermostat_triac_drive_top.sv -----
`timescale 1ns / 1ps

module tb_heater_thermostat_triac_drive_top;
	import htd_pkg::*;

	localparam logic [2:0] OP_UNUSED       = 3'd7;
	localparam int         TICKS_PER_TENTH = 20;
	localparam int         RANDOM_ITEMS    = 500;
	localparam int         HOLD_CYCLES     = 300;
	localparam int         CYCLE_LIMIT     = 200000;

	// result transfer layout, lowest bit is drive_on
	typedef struct packed {
		logic [1:0]         pad;
		status_t            status;
		logic               heating;
		logic signed [11:0] measured;
		logic [6:0]         power;
		logic [6:0]         setpoint;
		logic               drive;
	} result_t;

	// tracks thermostat state and holds the results still to come
	class thermostat_tracker;
		logic [6:0]         setpoint;
		logic [6:0]         power;
		logic signed [11:0] measured;
		logic [3:0]         on_tenths;
		logic [3:0]         off_tenths;
		logic [8:0]         phase;
		bit                 always_on;
		bit                 blanked;
		bit                 warm;
		bit                 next_on;
		bit                 heating;
		bit                 saved_heating;
		bit                 paused;
		bit                 drive;
		status_t            status;
		result_t            expected_q[$];
		int                 bad_results;

		function new();
			setpoint      = TEMP_RESET;
			power         = POWER_RESET;
			measured      = '0;
			on_tenths     = TENTHS_RESET;
			off_tenths    = TENTHS_RESET;
			phase         = PHASE_RESET;
			always_on     = 1'b0;
			blanked       = 1'b0;
			warm          = 1'b0;
			next_on       = 1'b0;
			heating       = 1'b0;
			saved_heating = 1'b0;
			paused        = 1'b0;
			drive         = 1'b1;
			status        = ST_START;
			bad_results   = 0;
		endfunction

		// on/off tenths from the power setting
		function void split_power();
			always_on = 1'b0;
			blanked   = 1'b0;
			if (power == 7'd0) begin
				on_tenths  = 4'd0;
				off_tenths = 4'd0;
				blanked    = 1'b1;
			end else if (power >= POWER_MAX) begin
				on_tenths  = TENTHS_FULL;
				off_tenths = 4'd0;
				always_on  = 1'b1;
			end else begin
				on_tenths  = 4'(power / 7'd10);
				off_tenths = 4'(10 - int'(on_tenths));
			end
		endfunction

		// on/off rule against the setpoint
		function void regulate();
			if (int'(measured) < int'(setpoint)) begin
				warm = 1'b0;
				if (!heating) begin
					status  = ST_WORKING;
					split_power();
					heating = 1'b1;
				end
			end else begin
				warm = 1'b1;
				if (heating) begin
					status  = ST_WARM;
					blanked = 1'b1;
					heating = 1'b0;
				end
			end
		endfunction

		// phase counter ran out
		function void end_phase();
			if (always_on) begin
				next_on = 1'b1;
				drive   = 1'b1;
				phase   = PHASE_FULL;
			end else if (blanked) begin
				next_on = 1'b0;
				drive   = 1'b0;
				phase   = PHASE_FULL;
			end else if (!warm) begin
				drive   = next_on;
				phase   = 9'((next_on ? int'(on_tenths) : int'(off_tenths))
					* TICKS_PER_TENTH + 1);
				next_on = !next_on;
			end else begin
				phase = PHASE_FULL;
			end
		endfunction

		// apply one accepted item; returns 0 when the item has no effect
		function bit note_item(logic [2:0] op, logic [15:0] raw);
			bit      was_paused;
			result_t r;
			was_paused = paused;
			case (op) inside
				OP_TICK: begin
					if (phase <= 9'd1) end_phase();
					else phase = phase - 9'd1;
				end
				OP_PAUSE: begin
					if (!paused) begin
						saved_heating = heating;
						heating       = 1'b0;
						blanked       = 1'b1;
						status        = ST_PAUSED;
						paused        = 1'b1;
					end else begin
						heating = saved_heating;
						blanked = 1'b0;
						split_power();
						paused  = 1'b0;
						regulate();
					end
				end
				OP_SAMPLE: begin
					measured = 12'(int'($signed(raw)) / 16);
					if (!paused) regulate();
				end
				OP_SET_UP, OP_SET_DOWN, OP_PWR_UP, OP_PWR_DOWN: begin
					if (!paused) begin
						case (op)
							OP_SET_UP:   if (setpoint < TEMP_MAX) setpoint = setpoint + 7'd1;
							OP_SET_DOWN: if (setpoint > TEMP_MIN) setpoint = setpoint - 7'd1;
							OP_PWR_UP: begin
								if (power < POWER_MAX) power = power + POWER_STEP;
								split_power();
							end
							default: begin
								if (power > 7'd0) power = power - POWER_STEP;
								split_power();
							end
						endcase
						regulate();
					end
				end
				default: ;
			endcase
			r.pad      = 2'b00;
			r.status   = status;
			r.heating  = heating;
			r.measured = measured;
			r.power    = power;
			r.setpoint = setpoint;
			r.drive    = drive;
			expected_q.push_back(r);
			return !((op >= OP_SET_UP && op <= OP_PWR_DOWN && was_paused)
				|| op == OP_UNUSED);
		endfunction

		function void compare(string field, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
				bad_results++;
			end
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(logic [31:0] data);
			result_t got;
			result_t want;
			got = result_t'(data);
			if (expected_q.size() == 0) begin
				$display("%0t: result %h with nothing expected, expected none", $time, data);
				bad_results++;
				return;
			end
			want = expected_q.pop_front();
			compare("drive_on", want.drive, got.drive);
			compare("setpoint", want.setpoint, got.setpoint);
			compare("power_percent", want.power, got.power);
			compare("measured", int'(want.measured), int'(got.measured));
			compare("heating", want.heating, got.heating);
			compare("status", int'(want.status), int'(got.status));
			compare("pad", want.pad, got.pad);
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	thermostat_tracker tracker;
	int                effective_items;
	int                cycles;
	bit                calm;
	bit                hold_off_req;

	heater_thermostat_triac_drive_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("heater_thermostat_triac_drive_top: mismatch");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_axis_tready <= arst_n && (calm || $urandom_range(0, 99) >= 6);
			end
		end
	end

	// result transfer checks
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata);
	end

	// offer one item, with an occasional gap before it
	task automatic send(logic [2:0] op, logic [15:0] raw);
		if (!calm && $urandom_range(0, 99) < 6) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= raw;
		do @(posedge clk); while (!s_axis_tready);
		if (tracker.note_item(op, raw))
			effective_items++;
	endtask

	// samples close to the current setpoint
	task automatic send_near_setpoint();
		int deg;
		deg = int'(tracker.setpoint) + $urandom_range(0, 6) - 3;
		send(OP_SAMPLE, 16'(deg * 16 + $urandom_range(0, 15)));
	endtask

	initial begin
		int          kind;
		int          n;
		bit          hold_done;
		logic [2:0]  op;

		tracker         = new();
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		s_axis_tuser    = OP_TICK;
		calm            = 1'b0;
		hold_off_req    = 1'b0;
		hold_done       = 1'b0;
		effective_items = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sample extremes, truncation of small negatives, the power clamp, pause
		send(OP_TICK, 16'hFFFF);
		send(OP_SAMPLE, 16'h0000);
		send(OP_SAMPLE, 16'h7FFF);
		send(OP_SAMPLE, 16'h8000);
		send(OP_SAMPLE, 16'hFFF1);
		send(OP_SAMPLE, 16'h0010);
		repeat (6) send(OP_PWR_UP, 16'h0000);
		send(OP_PAUSE, 16'h5555);
		send(OP_SET_UP, 16'hAAAA);
		send(OP_PWR_DOWN, 16'h0000);
		send(OP_TICK, 16'h0000);
		send(OP_SAMPLE, 16'h0400);
		send(OP_PAUSE, 16'h0000);
		send(OP_UNUSED, 16'hFFFF);
		send(OP_SET_DOWN, 16'h0000);
		send(OP_PWR_DOWN, 16'h0000);
		send(OP_SAMPLE, 16'h0200);
		send(OP_TICK, 16'h0000);

		// random scenarios until enough effective items
		effective_items = 0;
		while (effective_items < RANDOM_ITEMS) begin
			if (effective_items >= 150 && !hold_done) begin
				hold_off_req = 1'b1;
				hold_done    = 1'b1;
			end
			calm = (effective_items >= 300 && effective_items < 400);
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				// run of ticks long enough to expire phases
				n = $urandom_range(1, 260);
				repeat (n) send(OP_TICK, 16'($urandom));
			end else if (kind < 50) begin
				// burst of one button, reaching the clamps
				op = 3'($urandom_range(1, 4));
				n  = (op <= OP_SET_DOWN) ? $urandom_range(1, 45) : $urandom_range(1, 12);
				repeat (n) send(op, 16'($urandom));
			end else if (kind < 70) begin
				n = $urandom_range(1, 6);
				repeat (n) send_near_setpoint();
			end else if (kind < 80) begin
				// pause with traffic inside, usually resumed
				send(OP_PAUSE, 16'($urandom));
				n = $urandom_range(1, 8);
				repeat (n) send(3'($urandom_range(0, 6)), 16'($urandom));
				if ($urandom_range(0, 3) != 0) send(OP_PAUSE, 16'($urandom));
			end else begin
				// noise: any op code, any sample
				n = $urandom_range(1, 10);
				repeat (n) send(3'($urandom_range(0, 7)), 16'($urandom));
			end
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		// drain, then allow for stray results
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (tracker.bad_results == 0) begin
			$display("heater_thermostat_triac_drive_top: match");
		end else begin
			$display("heater_thermostat_triac_drive_top: mismatch");
		end
		$finish;
	end

endmodule
